// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the shelf packer.
// Clock and reset names follow the project convention (i_clk, i_rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/srp_pkg.sv =====
// Shared types, widths and codes for the shelf rectangle packer.
// No dependencies.
`timescale 1ns / 1ps

package srp_pkg;

    localparam int MAX_SHELVES_DEF = 64;
    localparam int DIM_W           = 13;
    localparam int SUM_W           = DIM_W + 1;
    localparam int COORD_W         = 12;
    localparam int CFG_IDX_W       = 2;

    localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH        = 2'd2;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] tall;
        logic [DIM_W-1:0] fill;
    } t_shelf;

    // operands of the shared fit unit
    typedef struct packed {
        logic             new_shelf;  // 1: test stack bottom, 0: test a shelf
        logic [DIM_W-1:0] req_w;
        logic [DIM_W-1:0] req_h;
        logic [DIM_W-1:0] lim_w;
        logic [DIM_W-1:0] lim_h;
        logic [DIM_W-1:0] bottom;
        t_shelf           shelf;
    } t_fit_req;

    typedef struct packed {
        logic             fit;
        logic [SUM_W-1:0] sum;
    } t_fit_rsp;

endpackage

// ===== rtl/core/shelf_rect_packer_core.sv =====
// Top level of the shelf rectangle packer: config registers and scan sequencer.
// Depends on srp_pkg, srp_shelf_mem, srp_fit_unit and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   Config: i_cfg_we with i_cfg_index / i_cfg_wdata writes a register at the
//   clock edge (0 atlas width, 1 atlas height, 2 flush on full). Write only
//   while busy is low.
//   Command: a word is taken at the edge where start is high and busy is low.
//   The result is on o_placed/o_slot_u/o_slot_v/o_cleared for one cycle while
//   o_strobe is high; the receiver cannot stall it.
//   Timing: a clear word answers in the cycle after it is taken. An allocate
//   scans the shelf table through one memory read port, one shelf a cycle,
//   with one shared add/compare unit, and opens a new shelf if none fits;
//   a failed attempt that flushes the table retries once on the empty table.
//   busy is high meanwhile; busy drops in the strobe cycle so the next word
//   may start then.
//   Reset (synchronous, active low) empties the table and loads the config
//   defaults; the shelf memory itself needs no clearing.
//
module shelf_rect_packer_core
    import srp_pkg::*;
#(
    parameter int MAX_SHELVES = MAX_SHELVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_operation,
    input  logic [DIM_W-1:0]     i_glyph_width,
    input  logic [DIM_W-1:0]     i_glyph_height,
    output logic                 o_strobe,
    output logic                 o_placed,
    output logic [COORD_W-1:0]   o_slot_u,
    output logic [COORD_W-1:0]   o_slot_v,
    output logic                 o_cleared
);

    localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int CNT_W = $clog2(MAX_SHELVES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SHELVES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_NEW
    } t_state;

    t_state           r_state;
    logic [DIM_W-1:0] r_atlas_width;
    logic [DIM_W-1:0] r_atlas_height;
    logic             r_flush_on_full;
    logic [CNT_W-1:0] r_count;
    logic [DIM_W-1:0] r_bottom;
    logic [DIM_W-1:0] r_w;
    logic [DIM_W-1:0] r_h;
    logic             r_retry;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cidx;
    logic             r_pend;

    logic [DIM_W-1:0] aw;
    logic [DIM_W-1:0] ah;
    logic             too_large;
    logic             more;
    logic             hit;
    logic             new_ok;
    t_shelf           rd_shelf;
    t_shelf           wr_shelf;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_fit_req         fit_req;
    t_fit_rsp         fit_rsp;
    logic [DIM_W-1:0] n_w;
    logic [DIM_W-1:0] n_h;

    assign aw   = (r_atlas_width  > DIM_LIMIT) ? DIM_LIMIT : r_atlas_width;
    assign ah   = (r_atlas_height > DIM_LIMIT) ? DIM_LIMIT : r_atlas_height;
    assign busy = (r_state != S_IDLE);

    // zero size counts as one pixel
    assign n_w = (i_glyph_width  == '0) ? DIM_W'(1) : i_glyph_width;
    assign n_h = (i_glyph_height == '0) ? DIM_W'(1) : i_glyph_height;

    always_comb begin
        fit_req.new_shelf = (r_state == S_NEW);
        fit_req.req_w     = r_w;
        fit_req.req_h     = r_h;
        fit_req.lim_w     = aw;
        fit_req.lim_h     = ah;
        fit_req.bottom    = r_bottom;
        fit_req.shelf     = rd_shelf;
    end

    srp_fit_unit u_fit (
        .i_req (fit_req),
        .o_rsp (fit_rsp)
    );

    always_comb begin
        too_large = (r_w > aw) || (r_h > ah);
        more      = (r_idx < r_count);
        hit       = (r_state == S_SCAN) && r_pend && fit_rsp.fit;
        new_ok    = (r_state == S_NEW) && fit_rsp.fit && (r_count < CNT_MAX);
        mem_we    = hit || new_ok;
        if (hit) begin
            mem_waddr     = r_cidx;
            wr_shelf.top  = rd_shelf.top;
            wr_shelf.tall = rd_shelf.tall;
            wr_shelf.fill = fit_rsp.sum[DIM_W-1:0];
        end else begin
            mem_waddr     = r_count[IDX_W-1:0];
            wr_shelf.top  = r_bottom;
            wr_shelf.tall = r_h;
            wr_shelf.fill = r_w;
        end
    end

    srp_shelf_mem #(
        .DEPTH (MAX_SHELVES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_shelf),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_shelf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_atlas_width   <= 13'd512;
            r_atlas_height  <= 13'd512;
            r_flush_on_full <= 1'b1;
            r_count         <= '0;
            r_bottom        <= '0;
            r_retry         <= 1'b0;
            r_pend          <= 1'b0;
            r_idx           <= '0;
            o_strobe        <= 1'b0;
            o_placed        <= 1'b0;
            o_cleared       <= 1'b0;
            o_slot_u        <= '0;
            o_slot_v        <= '0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ATLAS_WIDTH:  r_atlas_width   <= i_cfg_wdata;
                    CFG_ATLAS_HEIGHT: r_atlas_height  <= i_cfg_wdata;
                    CFG_FLUSH:        r_flush_on_full <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_w     <= n_w;
                        r_h     <= n_h;
                        r_retry <= 1'b0;
                        if (i_operation == OP_CLEAR) begin
                            r_count   <= '0;
                            r_bottom  <= '0;
                            o_strobe  <= 1'b1;
                            o_placed  <= 1'b0;
                            o_cleared <= 1'b1;
                            o_slot_u  <= '0;
                            o_slot_v  <= '0;
                        end else begin
                            o_cleared <= 1'b0;
                            r_state   <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    r_state <= too_large ? S_NEW : S_SCAN;
                end
                S_SCAN: begin
                    if (hit) begin
                        o_strobe <= 1'b1;
                        o_placed <= 1'b1;
                        o_slot_u <= rd_shelf.fill[COORD_W-1:0];
                        o_slot_v <= rd_shelf.top[COORD_W-1:0];
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (more) begin
                        // read for r_idx is in flight, compared next cycle
                        r_cidx <= r_idx[IDX_W-1:0];
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + CNT_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_NEW;
                    end
                end
                S_NEW: begin
                    if (new_ok && !too_large) begin
                        r_count  <= r_count + CNT_W'(1);
                        r_bottom <= fit_rsp.sum[DIM_W-1:0];
                        o_strobe <= 1'b1;
                        o_placed <= 1'b1;
                        o_slot_u <= '0;
                        o_slot_v <= r_bottom[COORD_W-1:0];
                        r_state  <= S_IDLE;
                    end else if (r_flush_on_full && !r_retry) begin
                        // flush the table and try once more
                        r_count   <= '0;
                        r_bottom  <= '0;
                        r_retry   <= 1'b1;
                        o_cleared <= 1'b1;
                        r_state   <= S_START;
                    end else begin
                        o_strobe <= 1'b1;
                        o_placed <= 1'b0;
                        o_slot_u <= '0;
                        o_slot_v <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_RST(a_count_bound, r_count <= CNT_MAX, "shelf count above table size")
    `ASSERT_RST(a_placed_cnt, (o_strobe && o_placed) |-> (r_count != '0), "placed, no shelf")
    `ASSERT_RST(a_strobe_cause, o_strobe |-> ($past(busy) || $past(start)), "stray result word")
    `ASSERT_RST(a_no_write_idle, (r_state == S_IDLE) |-> !mem_we, "shelf write while idle")

endmodule

// ===== rtl/core/srp_shelf_mem.sv =====
// Shelf table: one write port, one read port with registered read data.
// Depends on srp_pkg.
`timescale 1ns / 1ps

module srp_shelf_mem
    import srp_pkg::*;
#(
    parameter int DEPTH = MAX_SHELVES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_shelf           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_shelf           o_rdata
);

    t_shelf r_mem [DEPTH];
    t_shelf r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/srp_fit_unit.sv =====
// Shared fit test: one adder, limit and height compares, for scan and new-shelf test.
// Depends on srp_pkg.
`timescale 1ns / 1ps

module srp_fit_unit
    import srp_pkg::*;
(
    input  t_fit_req i_req,
    output t_fit_rsp o_rsp
);

    logic [DIM_W-1:0] opa;
    logic [DIM_W-1:0] opb;
    logic [DIM_W-1:0] lim;
    logic [SUM_W-1:0] sum;
    logic             tall_ok;

    always_comb begin
        opa     = i_req.new_shelf ? i_req.bottom : i_req.shelf.fill;
        opb     = i_req.new_shelf ? i_req.req_h  : i_req.req_w;
        lim     = i_req.new_shelf ? i_req.lim_h  : i_req.lim_w;
        sum     = {1'b0, opa} + {1'b0, opb};
        tall_ok = i_req.new_shelf || (i_req.req_h <= i_req.shelf.tall);
        o_rsp.sum = sum;
        o_rsp.fit = tall_ok && (sum <= {1'b0, lim});
    end

endmodule
